/* sv/qs_pkg.sv */
// ----------------------------------------------------------------------------
// qs_pkg
// Shared types and constants for the quicksort block: item and result
// payloads, range stack control, default store depth.
// ----------------------------------------------------------------------------
package qs_pkg;

  localparam int DEPTH_DEFAULT = 64;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } item_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               final_res;
  } result_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctl_t;

endpackage

/* sv/qs_stack.sv */
// ----------------------------------------------------------------------------
// qs_stack
// Range stack: synchronous memory of (low, high) index pairs with a stack
// pointer; a pop presents the top entry through a registered read.
// ----------------------------------------------------------------------------
module qs_stack #(
  parameter int DEPTH = qs_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  qs_pkg::stk_ctl_t           ctl,
  input  logic [$clog2(DEPTH)-1:0]   push_lo,
  input  logic [$clog2(DEPTH)-1:0]   push_hi,
  output logic [$clog2(DEPTH)-1:0]   pop_lo,
  output logic [$clog2(DEPTH)-1:0]   pop_hi,
  output logic                       empty
);
  import qs_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int PW = $clog2(DEPTH + 1);

  logic [2*IW-1:0] mem [DEPTH];
  logic [2*IW-1:0] rd;
  logic [PW-1:0]   sp;
  logic [PW-1:0]   sp_dec;
  logic            can_push;

  assign sp_dec   = sp - PW'(1);
  assign can_push = ctl.push && (sp < PW'(DEPTH));
  assign empty    = (sp == '0);
  assign pop_lo   = rd[2*IW-1:IW];
  assign pop_hi   = rd[IW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (can_push) begin
      sp <= sp + PW'(1);
    end else if (ctl.pop && !empty) begin
      sp <= sp_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (can_push) begin
      mem[sp[IW-1:0]] <= {push_lo, push_hi};
    end
    if (ctl.pop) begin
      rd <= mem[sp_dec[IW-1:0]];
    end
  end

endmodule

/* sv/qs_core.sv */
// ----------------------------------------------------------------------------
// qs_core
// Element store and sort sequencer: loads items, runs Hoare partitioning
// with a middle pivot over the store, then reads the store out in order.
// ----------------------------------------------------------------------------
module qs_core #(
  parameter int DEPTH = qs_pkg::DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  qs_pkg::item_t   item,
  input  logic            item_valid,
  output logic            item_ready,
  output qs_pkg::result_t emit,
  output logic            emit_valid,
  input  logic            emit_ready
);
  import qs_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = IW + 2;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_START  = 4'd1;
  localparam logic [3:0] S_POP    = 4'd2;
  localparam logic [3:0] S_POPW   = 4'd3;
  localparam logic [3:0] S_PIVGET = 4'd4;
  localparam logic [3:0] S_LOOP   = 4'd5;
  localparam logic [3:0] S_LSCAN  = 4'd6;
  localparam logic [3:0] S_RSCAN  = 4'd7;
  localparam logic [3:0] S_SWAP   = 4'd8;
  localparam logic [3:0] S_PUSH1  = 4'd9;
  localparam logic [3:0] S_PUSH2  = 4'd10;
  localparam logic [3:0] S_ERD    = 4'd11;
  localparam logic [3:0] S_EOUT   = 4'd12;

  logic [3:0]           state;
  logic [CW-1:0]        count;
  logic [CW-1:0]        eidx;
  logic [IW-1:0]        lo;
  logic [IW-1:0]        hi;
  logic signed [PW-1:0] l;
  logic signed [PW-1:0] r;
  logic signed [31:0]   pivot;
  logic signed [31:0]   vl;

  logic signed [31:0]   store [DEPTH];
  logic signed [31:0]   rdata;
  logic [IW-1:0]        rd_addr;
  logic                 we;
  logic [IW-1:0]        waddr;
  logic signed [31:0]   wdata;

  stk_ctl_t             stk;
  logic [IW-1:0]        push_lo;
  logic [IW-1:0]        push_hi;
  logic [IW-1:0]        pop_lo;
  logic [IW-1:0]        pop_hi;
  logic                 stk_empty;

  logic signed [PW-1:0] los;
  logic signed [PW-1:0] his;
  logic signed [PW-1:0] l_inc;
  logic signed [PW-1:0] r_dec;
  logic [IW:0]          mid_sum;
  logic [CW-1:0]        cnt_last;
  logic                 l_go;
  logic                 r_go;
  logic                 pop_bad;
  logic                 not_full;

  qs_stack #(.DEPTH(DEPTH)) u_stack (
    .clk     (clk),
    .rst     (rst),
    .ctl     (stk),
    .push_lo (push_lo),
    .push_hi (push_hi),
    .pop_lo  (pop_lo),
    .pop_hi  (pop_hi),
    .empty   (stk_empty)
  );

  assign los      = signed'({2'b00, lo});
  assign his      = signed'({2'b00, hi});
  assign l_inc    = l + PW'(1);
  assign r_dec    = r - PW'(1);
  assign mid_sum  = {1'b0, pop_lo} + {1'b0, pop_hi};
  assign cnt_last = count - CW'(1);
  assign l_go     = (l < his) && (rdata < pivot);
  assign r_go     = (r > los) && (rdata > pivot);
  assign pop_bad  = (pop_lo >= pop_hi) || (CW'(pop_hi) >= count);
  assign not_full = (count < CW'(DEPTH));

  assign item_ready        = (state == S_IDLE);
  assign emit_valid        = (state == S_EOUT);
  assign emit.sorted_value = rdata;
  assign emit.final_res    = (eidx == cnt_last);

  always_comb begin
    rd_addr = '0;
    case (state)
      S_POPW:          rd_addr = mid_sum[IW:1];
      S_LOOP:          rd_addr = l[IW-1:0];
      S_LSCAN:         rd_addr = l_go ? l_inc[IW-1:0] : r[IW-1:0];
      S_RSCAN:         rd_addr = r_dec[IW-1:0];
      S_ERD, S_EOUT:   rd_addr = eidx[IW-1:0];
      default:         rd_addr = '0;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    stk   = '0;
    push_lo = '0;
    push_hi = '0;
    unique case (state)
      S_IDLE: begin
        we    = item_valid && not_full;
        waddr = count[IW-1:0];
        wdata = item.value;
      end
      S_START: begin
        stk.push = (count >= CW'(2));
        push_lo  = '0;
        push_hi  = cnt_last[IW-1:0];
      end
      S_POP: begin
        stk.pop = !stk_empty;
      end
      S_RSCAN: begin
        we    = !r_go && (l <= r);
        waddr = l[IW-1:0];
        wdata = rdata;
      end
      S_SWAP: begin
        we    = 1'b1;
        waddr = r[IW-1:0];
        wdata = vl;
      end
      S_PUSH1: begin
        stk.push = (l < his);
        push_lo  = l[IW-1:0];
        push_hi  = hi;
      end
      S_PUSH2: begin
        stk.push = (los < r);
        push_lo  = lo;
        push_hi  = r[IW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
    rdata <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            if (not_full) begin
              count <= count + CW'(1);
            end
            if (item.last) begin
              state <= S_START;
            end
          end
        end
        S_START: begin
          state <= S_POP;
        end
        S_POP: begin
          if (stk_empty) begin
            eidx  <= '0;
            state <= S_ERD;
          end else begin
            state <= S_POPW;
          end
        end
        S_POPW: begin
          lo    <= pop_lo;
          hi    <= pop_hi;
          state <= pop_bad ? S_POP : S_PIVGET;
        end
        S_PIVGET: begin
          pivot <= rdata;
          l     <= los;
          r     <= his;
          state <= S_LOOP;
        end
        S_LOOP: begin
          state <= (l <= r) ? S_LSCAN : S_PUSH1;
        end
        S_LSCAN: begin
          if (l_go) begin
            l <= l_inc;
          end else begin
            vl    <= rdata;
            state <= S_RSCAN;
          end
        end
        S_RSCAN: begin
          if (r_go) begin
            r <= r_dec;
          end else if (l <= r) begin
            state <= S_SWAP;
          end else begin
            state <= S_LOOP;
          end
        end
        S_SWAP: begin
          l     <= l_inc;
          r     <= r_dec;
          state <= S_LOOP;
        end
        S_PUSH1: begin
          state <= S_PUSH2;
        end
        S_PUSH2: begin
          state <= S_POP;
        end
        S_ERD: begin
          state <= S_EOUT;
        end
        S_EOUT: begin
          if (emit_ready) begin
            if (eidx == cnt_last) begin
              count <= '0;
              state <= S_IDLE;
            end else begin
              eidx  <= eidx + CW'(1);
              state <= S_ERD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    stk.pop |-> !stk_empty)
    else $error("range stack popped while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("element count above depth");

  a_lscan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_LSCAN) |-> (l <= his))
    else $error("left scan ran past range");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (emit_valid && emit_ready && emit.final_res) |=> (count == '0 && state == S_IDLE))
    else $error("store not emptied after final transfer");

endmodule

/* sv/quicksort_hoare_middle_pivot.sv */
// ----------------------------------------------------------------------------
// quicksort_hoare_middle_pivot
// Collects signed elements, sorts them with quicksort and streams them out
// in ascending order, flagging the final one.
// ----------------------------------------------------------------------------
// Items load at one per cycle while the block is idle into a single-port-read
// element store; the item marked last starts the sort. Sorting is paced by
// the store's one read per cycle: each range is popped, its middle pivot is
// fetched, the range is scanned and swapped, and its subranges are pushed.
// Output then reads each element through the store read port, and the output
// register lets a result wait while the store is read. No new item is taken
// from the last item until the final result has moved into the output
// register. Elements past DEPTH are dropped; memories need no clearing.
// ----------------------------------------------------------------------------
module quicksort_hoare_middle_pivot #(
  parameter int DEPTH = qs_pkg::DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  qs_pkg::item_t   item,
  input  logic            item_valid,
  output logic            item_ready,
  output qs_pkg::result_t result,
  output logic            result_valid,
  input  logic            result_ready
);
  import qs_pkg::*;

  result_t emit;
  logic    emit_valid;
  logic    emit_ready;

  qs_core #(.DEPTH(DEPTH)) u_core (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .emit       (emit),
    .emit_valid (emit_valid),
    .emit_ready (emit_ready)
  );

  assign emit_ready = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_ready) begin
      result_valid <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid && emit_ready) begin
      result <= emit;
    end
  end

endmodule
